>>> src/hwip_pkg.sv
// Shared types, codes and hash constants for the hashed weighted index pick block.
package hwip_pkg;

	// Function codes of a request
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_LEN   = 2'd1;
	localparam logic [1:0] FUNC_PICK  = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// Mixer constants
	localparam logic [31:0] MIX_GOLD = 32'd2654435761;
	localparam logic [31:0] MIX_C1   = 32'd2246822519;
	localparam logic [31:0] MIX_C2   = 32'd3266489917;

	// Number of distinct slot salts
	localparam int SALTED_SLOTS = 7;

	typedef struct packed {
		logic [1:0]         func;
		logic [2:0]         slot;
		logic [3:0]         entry_index;
		logic signed [31:0] weight;
		logic [4:0]         list_len;
		logic signed [31:0] employee_id;
	} req_t;

	typedef struct packed {
		logic signed [4:0] picked_index;
		logic              none_found;
	} rsp_t;

	// Slot salt already multiplied by the golden constant; slots 0 and 7 share the default salt
	function automatic logic [31:0] salt_premix(input logic [2:0] slot);
		logic [63:0] p;
		begin
			case (slot)
				3'd1:    p = 64'h846CA68B * 64'(MIX_GOLD);
				3'd2:    p = 64'hD168AAAD * 64'(MIX_GOLD);
				3'd3:    p = 64'hAF251AF3 * 64'(MIX_GOLD);
				3'd4:    p = 64'hB55A4F09 * 64'(MIX_GOLD);
				3'd5:    p = 64'h1B03738C * 64'(MIX_GOLD);
				3'd6:    p = 64'h4DD81482 * 64'(MIX_GOLD);
				default: p = 64'h7FEB352D * 64'(MIX_GOLD);
			endcase
			salt_premix = p[31:0];
		end
	endfunction

endpackage

>>> src/hashed_weighted_index_pick.sv
// Top level of the hashed weighted index pick block.
//
// Requests enter on req/req_valid/req_stall; a transaction is taken at a
// rising edge with req_valid high and req_stall low. A write or set-length
// request stores into the slot tables and gives no response. A pick request
// gives one response on rsp/rsp_valid/rsp_stall: the chosen index, or -1
// with none_found set when the list holds no positive weight.
// Requests pass a two-entry queue; req_stall rises only when it is full.
// Writes and lengths are applied as the back end pops them while idle. A
// pick of a list of length n > 0 passes the queue, the hash steps, the sum
// pass over the weight memory (one write port, one registered read port),
// the bit-serial modulo, the pick pass and the load of the response
// register; an empty list or a zero total skips the modulo and pick pass.
// While rsp_stall holds a response, the back end finishes the next pick
// and waits to load it; the queue keeps accepting until full.
// Reset clears both tables (weights through per-entry valid bits), the
// queue and the response valid flag at once.
module hashed_weighted_index_pick #(
	parameter int MAX_ENTRIES = 16,
	parameter int NUM_SLOTS   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hwip_pkg::req_t  req,
	input  logic            req_valid,
	output logic            req_stall,
	output hwip_pkg::rsp_t  rsp,
	output logic            rsp_valid,
	input  logic            rsp_stall
);

	hwip_pkg::req_t q_item;
	logic           q_valid;
	logic           q_pop;

	hwip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop)
	);

	hwip_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.NUM_SLOTS   (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

>>> src/hwip_front.sv
// Front end: accepts requests, drops unused function codes, queues the rest.
module hwip_front (
	input  logic              clk,
	input  logic              arst_n,
	input  hwip_pkg::req_t    req,
	input  logic              req_valid,
	output logic              req_stall,
	output hwip_pkg::req_t    q_item,
	output logic              q_valid,
	input  logic              q_pop
);

	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	hwip_pkg::req_t         fifo_q [2];
	logic                   push;

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall && (req.func != hwip_pkg::FUNC_NONE);
	assign q_valid   = (count_q != 2'd0);
	assign q_item    = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/hwip_back.sv
// Back end: weight memory, length table, hash, sum walk, modulo and pick walk.
module hwip_back #(
	parameter int MAX_ENTRIES = 16,
	parameter int NUM_SLOTS   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hwip_pkg::req_t    q_item,
	input  logic              q_valid,
	output logic              q_pop,
	output hwip_pkg::rsp_t    rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);

	localparam int DEPTH = NUM_SLOTS * MAX_ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = $clog2(NUM_SLOTS);
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W = 32 + $clog2(MAX_ENTRIES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]       state_q;
	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] ent_vld_q;
	logic [CW-1:0]    len_q [NUM_SLOTS];
	logic [31:0]      rd_data_s1;
	logic             rd_ok_s1;
	logic             rd_pend_s1;
	logic [AW-1:0]    base_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    iss_q;
	logic [CW-1:0]    dat_q;
	logic [31:0]      h_q;
	logic [1:0]       hstep_q;
	logic [SUM_W-1:0] total_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] acc_q;
	logic [4:0]       mcnt_q;
	logic [4:0]       res_idx_q;
	logic             res_none_q;
	hwip_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic             slot_ok;
	logic             entry_ok;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;
	logic             rd_issue;
	logic [SUM_W-1:0] w_clamped;
	logic [SUM_W-1:0] acc_next;
	logic [SUM_W:0]   rem_sh;
	logic [SUM_W:0]   rem_diff;
	logic [63:0]      mul_in;
	logic [63:0]      mul_out;
	logic [31:0]      h_shift;
	logic             out_free;
	logic             rsp_load;

	assign slot_ok  = (32'(q_item.slot) < NUM_SLOTS);
	assign entry_ok = (32'(q_item.entry_index) < MAX_ENTRIES);
	assign wr_addr  = AW'(32'(q_item.slot) * MAX_ENTRIES + 32'(q_item.entry_index));
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign mem_we   = q_pop && (q_item.func == hwip_pkg::FUNC_WRITE) && slot_ok && entry_ok;
	assign rd_issue = ((state_q == ST_SUM) || (state_q == ST_WALK)) && (iss_q < n_q);
	assign rd_addr  = base_q + AW'(iss_q);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = (state_q == ST_OUT) && out_free;

	// Negative or never written weights count as zero
	assign w_clamped = (rd_ok_s1 && !rd_data_s1[31]) ? SUM_W'(rd_data_s1) : '0;
	assign acc_next  = acc_q + w_clamped;

	// One restoring division step
	assign rem_sh   = {rem_q, h_q[31]};
	assign rem_diff = rem_sh - {1'b0, total_q};

	// Mixer step: xorshift then one multiply
	always_comb begin
		case (hstep_q)
			2'd0:    h_shift = h_q ^ (h_q >> 16);
			default: h_shift = h_q ^ (h_q >> 13);
		endcase
		mul_in  = 64'(h_shift);
		if (hstep_q == 2'd0) begin
			mul_out = mul_in * 64'(hwip_pkg::MIX_C1);
		end else begin
			mul_out = mul_in * 64'(hwip_pkg::MIX_C2);
		end
	end

	// Weight memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= q_item.weight;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// Entry valid bits, length table and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= '0;
			rd_ok_s1   <= 1'b0;
			rd_pend_s1 <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			rd_ok_s1   <= ent_vld_q[rd_addr];
			rd_pend_s1 <= rd_issue;
			if (mem_we) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			if (q_pop && (q_item.func == hwip_pkg::FUNC_LEN) && slot_ok) begin
				if (32'(q_item.list_len) > MAX_ENTRIES) begin
					len_q[SW'(q_item.slot)] <= CW'(MAX_ENTRIES);
				end else begin
					len_q[SW'(q_item.slot)] <= CW'(q_item.list_len);
				end
			end
		end
	end

	// Pick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && (q_item.func == hwip_pkg::FUNC_PICK)) begin
						h_q     <= q_item.employee_id ^ hwip_pkg::salt_premix(q_item.slot);
						hstep_q <= 2'd0;
						base_q  <= AW'(32'(q_item.slot) * MAX_ENTRIES);
						if (slot_ok) begin
							n_q     <= len_q[SW'(q_item.slot)];
							state_q <= ST_HASH;
						end else begin
							res_idx_q  <= 5'h1F;
							res_none_q <= 1'b1;
							state_q    <= ST_OUT;
						end
					end
				end
				ST_HASH: begin
					hstep_q <= hstep_q + 2'd1;
					if (hstep_q == 2'd2) begin
						h_q     <= h_q ^ (h_q >> 16);
						iss_q   <= '0;
						dat_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_SUM;
					end else begin
						h_q <= mul_out[31:0];
					end
				end
				ST_SUM: begin
					if (rd_issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (rd_pend_s1) begin
						acc_q <= acc_next;
					end
					if (!rd_issue && !rd_pend_s1) begin
						total_q <= acc_q;
						rem_q   <= '0;
						mcnt_q  <= '0;
						if (acc_q == '0) begin
							res_idx_q  <= 5'h1F;
							res_none_q <= 1'b1;
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					h_q    <= h_q << 1;
					mcnt_q <= mcnt_q + 5'd1;
					if (rem_diff[SUM_W]) begin
						rem_q <= rem_sh[SUM_W-1:0];
					end else begin
						rem_q <= rem_diff[SUM_W-1:0];
					end
					if (mcnt_q == 5'd31) begin
						iss_q   <= '0;
						dat_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (rd_issue) begin
						iss_q <= iss_q + CW'(1);
					end
					if (rd_pend_s1) begin
						acc_q <= acc_next;
						dat_q <= dat_q + CW'(1);
						if (rem_q < acc_next) begin
							res_idx_q  <= 5'(dat_q);
							res_none_q <= 1'b0;
							state_q    <= ST_OUT;
						end
					end else if (!rd_issue) begin
						// walk ran out without a hit: answer the last index
						res_idx_q  <= 5'(n_q - CW'(1));
						res_none_q <= 1'b0;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						rsp_q.picked_index <= res_idx_q;
						rsp_q.none_found   <= res_none_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_mod_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (total_q != '0))
		else $error("modulo running on a zero total");

	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.none_found) |-> (rsp_q.picked_index == 5'h1F))
		else $error("empty list without all-ones index");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && rd_pend_s1) |-> (dat_q < n_q))
		else $error("walk data index past list length");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SUM) || (state_q == ST_WALK)) |-> (iss_q <= n_q))
		else $error("read issue past list length");

endmodule

>>> tb/hashed_weighted_index_pick_tb.sv
// Testbench for the hashed weighted index pick block: directed table plus random traffic.
`timescale 1ns / 100ps

module hashed_weighted_index_pick_tb;

	localparam int ENTRIES  = 16;
	localparam int SLOTS    = 8;
	localparam int RAND_ITEMS = 1350;
	localparam longint CYCLE_LIMIT = 800000;

	logic           clk;
	logic           arst_n;
	hwip_pkg::req_t req;
	logic           req_valid;
	logic           req_stall;
	hwip_pkg::rsp_t rsp;
	logic           rsp_valid;
	logic           rsp_stall;

	hashed_weighted_index_pick uut (
		.clk(clk), .arst_n(arst_n), .req(req), .req_valid(req_valid),
		.req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
	);

	// Shadow copy of the block's tables
	logic [31:0]    weights [SLOTS][ENTRIES];
	logic [4:0]     list_lens [SLOTS];
	hwip_pkg::rsp_t pending_picks [$];
	int             errors;
	longint         cycles;
	logic           idle_free;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		begin
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		end
	endtask

	function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		begin
			p = 64'(a) * 64'(b);
			return p[31:0];
		end
	endfunction

	function automatic logic [31:0] slot_salt(input logic [2:0] s);
		case (s)
			3'd1: return 32'h846CA68B;
			3'd2: return 32'hD168AAAD;
			3'd3: return 32'hAF251AF3;
			3'd4: return 32'hB55A4F09;
			3'd5: return 32'h1B03738C;
			3'd6: return 32'h4DD81482;
			default: return 32'h7FEB352D;
		endcase
	endfunction

	function automatic logic [31:0] hash_id(input logic [31:0] id, input logic [2:0] s);
		logic [31:0] h;
		begin
			h = id ^ mul_lo(slot_salt(s), 32'd2654435761);
			h = h ^ (h >> 16);
			h = mul_lo(h, 32'd2246822519);
			h = h ^ (h >> 13);
			h = mul_lo(h, 32'd3266489917);
			h = h ^ (h >> 16);
			return h;
		end
	endfunction

	// Apply one accepted request to the shadow tables; push a pick's answer
	task automatic predict_request(input hwip_pkg::req_t r);
		logic [35:0] total, roll, acc;
		int n;
		hwip_pkg::rsp_t a;
		begin
			case (r.func)
				hwip_pkg::FUNC_WRITE: weights[r.slot][r.entry_index] = r.weight;
				hwip_pkg::FUNC_LEN:
					list_lens[r.slot] = (r.list_len > ENTRIES) ? 5'(ENTRIES) : r.list_len;
				hwip_pkg::FUNC_PICK: begin
					n = list_lens[r.slot];
					total = '0;
					for (int i = 0; i < n; i++)
						if (!weights[r.slot][i][31]) total += 36'(weights[r.slot][i]);
					if (total == 0) begin
						a.picked_index = -5'sd1;
						a.none_found = 1'b1;
					end else begin
						roll = 36'(hash_id(r.employee_id, r.slot)) % total;
						a.picked_index = 5'(n - 1);
						a.none_found = 1'b0;
						acc = '0;
						for (int i = 0; i < n; i++) begin
							if (!weights[r.slot][i][31]) acc += 36'(weights[r.slot][i]);
							if (roll < acc) begin
								a.picked_index = 5'(i);
								break;
							end
						end
					end
					pending_picks.push_back(a);
				end
				default: ;
			endcase
		end
	endtask

	// Response checker and random response stall
	always @(posedge clk) begin
		hwip_pkg::rsp_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_picks.size() == 0) begin
					report_mismatch("response with nothing expected");
				end else begin
					e = pending_picks.pop_front();
					if (rsp.picked_index !== e.picked_index)
						report_mismatch($sformatf("picked_index %0d, expected %0d",
							rsp.picked_index, e.picked_index));
					if (rsp.none_found !== e.none_found)
						report_mismatch($sformatf("none_found %0b, expected %0b",
							rsp.none_found, e.none_found));
				end
			end
			rsp_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 25);
		end
	end

	// Present one request and hold it until accepted
	task automatic send_request(input hwip_pkg::req_t r, input logic with_gaps);
		begin
			while (with_gaps && !idle_free && $urandom_range(99) < 25) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
			req <= r;
			req_valid <= 1'b1;
			@(posedge clk);
			while (req_stall) @(posedge clk);
			predict_request(r);
		end
	endtask

	function automatic hwip_pkg::req_t make_req(input logic [1:0] f, input logic [2:0] s,
		input logic [3:0] e, input logic [31:0] w, input logic [4:0] l, input logic [31:0] id);
		hwip_pkg::req_t r;
		begin
			r.func = f; r.slot = s; r.entry_index = e;
			r.weight = w; r.list_len = l; r.employee_id = id;
			return r;
		end
	endfunction

	function automatic hwip_pkg::req_t random_req();
		hwip_pkg::req_t r;
		logic [95:0] raw;
		int k;
		begin
			raw = {$urandom, $urandom, $urandom};
			r = raw[$bits(hwip_pkg::req_t)-1:0];
			k = $urandom_range(99);
			// Well-formed traffic mostly: writes with weights of mixed size, lengths, picks
			if (k < 40) begin
				r.func = hwip_pkg::FUNC_WRITE;
				case ($urandom_range(3))
					0: r.weight = $urandom;
					1: r.weight = $urandom_range(1000);
					2: r.weight = $urandom_range(3);
					default: r.weight = {1'b0, 31'($urandom)};
				endcase
			end else if (k < 50) begin
				r.func = hwip_pkg::FUNC_LEN;
				r.list_len = 5'($urandom_range(16));
				if ($urandom_range(9) == 0) r.list_len = 5'($urandom_range(31));
			end else if (k < 95) begin
				r.func = hwip_pkg::FUNC_PICK;
			end else begin
				r.func = hwip_pkg::FUNC_NONE;
			end
			return r;
		end
	endfunction

	typedef struct {
		hwip_pkg::req_t r;
		logic           typed;
		hwip_pkg::rsp_t answer;
	} directed_row_t;

	directed_row_t dir_rows [$];

	function automatic void add_row(input hwip_pkg::req_t r, input logic typed,
		input logic [4:0] idx, input logic nf);
		directed_row_t d;
		begin
			d.r = r; d.typed = typed;
			d.answer.picked_index = idx; d.answer.none_found = nf;
			dir_rows.push_back(d);
		end
	endfunction

	initial begin
		hwip_pkg::rsp_t sum_before;
		errors = 0;
		cycles = 0;
		idle_free = 1'b0;
		arst_n = 1'b0;
		req = '0;
		req_valid = 1'b0;
		rsp_stall = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			list_lens[s] = '0;
			for (int e = 0; e < ENTRIES; e++) weights[s][e] = '0;
		end

		// Directed table: empty after reset, extremes, ignored codes, saturation
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd0, '0, '0, '0, 32'h0), 1'b1, 5'h1F, 1'b1);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd7, '0, '0, '0, 32'hFFFFFFFF), 1'b1, 5'h1F,
			1'b1);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd0, 4'd0, 32'h80000000, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_LEN, 3'd0, '0, '0, 5'd1, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd0, '0, '0, '0, 32'h7FFFFFFF), 1'b1, 5'h1F,
			1'b1);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd0, 4'd0, 32'h7FFFFFFF, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd0, '0, '0, '0, 32'h80000000), 1'b1, 5'd0,
			1'b0);
		add_row(make_req(hwip_pkg::FUNC_LEN, 3'd1, '0, '0, 5'd31, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd1, 4'd15, 32'd5, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd1, '0, '0, '0, 32'h12345678), 1'b1, 5'd15,
			1'b0);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd1, 4'd3, 32'h7FFFFFFF, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd1, 4'd7, 32'h7FFFFFFF, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd1, '0, '0, '0, 32'hDEADBEEF), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_NONE, 3'd1, 4'd0, 32'd9, 5'd3, 32'h1), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd7, 4'd0, 32'd100, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_LEN, 3'd7, '0, '0, 5'd16, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd7, '0, '0, '0, 32'h0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_LEN, 3'd1, '0, '0, 5'd3, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd1, '0, '0, '0, 32'h55AA55AA), 1'b1, 5'h1F,
			1'b1);
		add_row(make_req(hwip_pkg::FUNC_LEN, 3'd6, '0, '0, 5'd2, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_WRITE, 3'd6, 4'd1, 32'd1, '0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd6, '0, '0, '0, 32'hAAAAAAAA), 1'b1, 5'd1,
			1'b0);
		add_row(make_req(hwip_pkg::FUNC_LEN, 3'd1, '0, '0, 5'd0, '0), 1'b0, '0, '0);
		add_row(make_req(hwip_pkg::FUNC_PICK, 3'd1, '0, '0, '0, 32'h1), 1'b1, 5'h1F, 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].r, 1'b1);
			// Typed answers must agree with the predictor's own expectation
			if (dir_rows[i].typed) begin
				sum_before = pending_picks[pending_picks.size() - 1];
				if (sum_before !== dir_rows[i].answer)
					report_mismatch($sformatf("directed row %0d expectation disagrees", i));
			end
		end

		// Sender holds off until every pick has come back
		req_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			idle_free <= (n >= 500 && n < 700);
			send_request(random_req(), 1'b1);
		end
		req_valid <= 1'b0;
		idle_free <= 1'b0;

		while (pending_picks.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
src/hwip_pkg.sv
src/hwip_front.sv
src/hwip_back.sv
src/hashed_weighted_index_pick.sv
tb/hashed_weighted_index_pick_tb.sv
